/* hw/rtl/ifas_pkg.sv */
// Package for the isolation forest anomaly scorer: sizes, node word layout,
// state machine type and the functions behind the c(n) and 2^(-2^-k) root constant tables.
// No dependencies.
package ifas_pkg;

  localparam int MaxTrees    = 128;
  localparam int MaxNodes    = 512;
  localparam int MaxFeatures = 4;
  localparam int TreeW       = $clog2(MaxTrees);
  localparam int NodeW       = $clog2(MaxNodes);
  localparam int AddrW       = TreeW + NodeW;
  localparam int CntW        = NodeW + 1;

  localparam logic [1:0] CfgTreeCount    = 2'd0;
  localparam logic [1:0] CfgSampleSize   = 2'd1;
  localparam logic [1:0] CfgFeatureCount = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StLoad, StCnt, StTree, StRead, StNode, StLeaf, StSum, StDiv, StMulC, StExp,
    StExpMul, StOut
  } state_e;

  typedef struct packed {
    logic signed [2:0]  split_feature;
    logic signed [31:0] split_value;
    logic signed [9:0]  left_child;
    logic signed [9:0]  right_child;
    logic [8:0]         leaf_size;
  } node_t;

  // c(n) in Q.16, evaluated at elaboration as the model defines it
  function automatic logic [31:0] c_of(input int unsigned n);
    logic [63:0] v, m, frac, ln, c;
    int unsigned e;
    if (n <= 1) return 32'd0;
    if (n == 2) return 32'd65536;
    v = 64'(n - 1);
    e = 0;
    frac = 64'd0;
    while ((v >> (e + 1)) != 64'd0) e++;
    m = v << (30 - e);
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << b);
      end
    end
    ln = 64'(e) * 64'd2977044472 + ((frac * 64'd2977044472) >> 32);
    c = 64'd2 * (ln + 64'd2479122404) - ((64'(n - 1) << 33) / 64'(n));
    return 32'((c + 64'd32768) >> 16);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] xin);
    logic [63:0] x, r, bt;
    x = xin;
    r = 64'd0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [32:0] root_of(input int unsigned k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      if (i <= int'(k)) r = isqrt(r << 32);
    end
    return 33'(r);
  endfunction

endpackage

/* hw/rtl/ifas_node_ram.sv */
// Node store: one write port, one registered read port.
// Depends on ifas_pkg.
module ifas_node_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ifas_pkg::AddrW-1:0] waddr_i,
  input  ifas_pkg::node_t           wdata_i,
  input  logic [ifas_pkg::AddrW-1:0] raddr_i,
  output ifas_pkg::node_t           rdata_o
);
  ifas_pkg::node_t mem_q [2**ifas_pkg::AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/isolation_forest_anomaly_score.sv */
// Isolation forest anomaly scorer, top level.
// Depends on ifas_pkg and ifas_node_ram.
//
// Usage: a word is taken when start is high and busy low. action_i 0 loads
// one tree node into the node store (busy in StLoad after the word, no
// result); the per-tree node count is read from its own memory and raised
// when the node lies past it. action_i 1 scores the feature vector: for each
// tree the node count is read (StCnt, StTree), then every visited node passes
// StRead (memory read) and StNode (compare), and a leaf also StLeaf for the
// c(size) lookup. The mean path comes from a restoring divider, is scaled by
// 1/c(sample_size) (41-bit divide) and turned into 2^(-x) by 16 multiply
// steps. busy holds for the whole item, one item at a time; with no trees
// configured the scorer goes straight to StOut. The result shows on
// anomaly_score_o and mean_path_length_o with done_o high for one cycle, the
// first cycle with busy low; the receiver cannot stall. Configuration writes
// use cfg_valid_i/cfg_ready_o, always ready. Reset clears the node count
// valid flags, state and done_o, sets tree count 0, sample size 256, feature
// count 3; other registers and node store contents are undefined until loaded.
module isolation_forest_anomaly_score (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               action_i,
  input  logic [6:0]         tree_index_i,
  input  logic [8:0]         node_index_i,
  input  logic signed [2:0]  split_feature_i,
  input  logic signed [31:0] split_value_i,
  input  logic signed [9:0]  left_child_i,
  input  logic signed [9:0]  right_child_i,
  input  logic [8:0]         leaf_size_i,
  input  logic signed [31:0] feature_zero_i,
  input  logic signed [31:0] feature_one_i,
  input  logic signed [31:0] feature_two_i,
  input  logic signed [31:0] feature_three_i,
  output logic               done_o,
  output logic [16:0]        anomaly_score_o,
  output logic [23:0]        mean_path_length_o
);
  localparam int TW = ifas_pkg::TreeW;
  localparam int NW = ifas_pkg::NodeW;
  localparam int CW = ifas_pkg::CntW;

  ifas_pkg::state_e state_q, state_d;
  logic [7:0] tree_count_q;
  logic [8:0] sample_size_q;
  logic [2:0] feature_count_q;

  // per-tree node counts: memory plus valid flags cleared by reset
  logic [CW-1:0] cnt_mem [ifas_pkg::MaxTrees];
  logic          cnt_vld_q [ifas_pkg::MaxTrees];
  logic [CW-1:0] cnt_rd_q;
  logic          cnt_vld_rd_q;
  logic [TW-1:0] cnt_raddr;
  logic          cnt_we;
  logic [CW-1:0] ld_next;
  logic [TW-1:0] ld_tree_q;
  logic [NW-1:0] ld_node_q;

  logic signed [31:0] feat_q [ifas_pkg::MaxFeatures];
  logic [TW:0]   tree_q;
  logic [TW:0]   trees_q;
  logic [2:0]    nfeat_q;
  logic [NW-1:0] idx_q;
  logic [CW-1:0] steps_q;
  logic [CW-1:0] depth_q;
  logic [40:0]   sum_q;
  logic [40:0]   rem_q;
  logic [40:0]   quo_q;
  logic [5:0]    bit_q;
  logic [23:0]   mean_q;
  logic [31:0]   cn_q;
  logic [32:0]   s_q;
  logic [65:0]   prod_q;
  logic [4:0]    k_q;
  logic [31:0]   x_q;
  logic [16:0]   score_q;
  logic          done_q;

  ifas_pkg::node_t node_w, rd_node;
  logic [ifas_pkg::AddrW-1:0] raddr;
  logic we;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != ifas_pkg::StIdle);
  assign done_o = done_q;
  assign anomaly_score_o = score_q;
  assign mean_path_length_o = mean_q;

  assign node_w = '{split_feature_i, split_value_i, left_child_i, right_child_i, leaf_size_i};
  assign we = start && !busy && !action_i;
  assign raddr = {tree_q[TW-1:0], idx_q};

  ifas_node_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i({tree_index_i, node_index_i}),
    .wdata_i(node_w),
    .raddr_i(raddr),
    .rdata_o(rd_node)
  );

  // c table and root table as constant arrays
  logic [31:0] c_tab [512];
  logic [32:0] r_tab [17];
  always_comb begin
    for (int n = 0; n < 512; n++) c_tab[n] = ifas_pkg::c_of(n);
    for (int k = 0; k < 17; k++) r_tab[k] = ifas_pkg::root_of(k);
  end

  // c(n) lookup with a registered read: leaf size while at a node, else sample size
  logic [8:0]  c_addr;
  logic [31:0] c_rd_q;
  assign c_addr = (state_q == ifas_pkg::StNode) ? rd_node.leaf_size : sample_size_q;
  always_ff @(posedge clk_i) begin
    c_rd_q <= c_tab[c_addr];
  end

  assign cnt_raddr = (state_q == ifas_pkg::StIdle) ? tree_index_i : tree_q[TW-1:0];
  assign ld_next = {1'b0, ld_node_q} + CW'(1);

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[ld_tree_q] <= ld_next;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // node evaluation
  logic signed [31:0] fsel;
  logic go_left, is_leaf;
  logic signed [9:0] child;
  logic [CW-1:0] cur_cnt;
  always_comb begin
    fsel = feat_q[rd_node.split_feature[1:0]];
    go_left = (rd_node.split_feature >= 0) &&
              ({1'b0, rd_node.split_feature[1:0]} < nfeat_q) &&
              (fsel < rd_node.split_value);
    is_leaf = rd_node.split_feature[2] ||
              (rd_node.left_child[9] && rd_node.right_child[9]);
    child = go_left ? rd_node.left_child : rd_node.right_child;
    cur_cnt = cnt_vld_rd_q ? cnt_rd_q : '0;
  end

  assign cnt_we = (state_q == ifas_pkg::StLoad) && (ld_next > cur_cnt);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ifas_pkg::StIdle: if (start) begin
        if (action_i) begin
          state_d = (tree_count_q == 8'd0) ? ifas_pkg::StOut : ifas_pkg::StCnt;
        end else begin
          state_d = ifas_pkg::StLoad;
        end
      end
      ifas_pkg::StLoad: state_d = ifas_pkg::StIdle;
      ifas_pkg::StCnt: state_d = ifas_pkg::StTree;
      ifas_pkg::StTree: begin
        if (tree_q == trees_q) state_d = ifas_pkg::StSum;
        else if (cur_cnt == '0) state_d = ifas_pkg::StCnt;
        else state_d = ifas_pkg::StRead;
      end
      ifas_pkg::StRead: state_d = ifas_pkg::StNode;
      ifas_pkg::StNode: begin
        if (is_leaf) state_d = ifas_pkg::StLeaf;
        else if (child[9]) state_d = ifas_pkg::StCnt;
        else if ({1'b0, child[8:0]} >= cur_cnt ||
                 steps_q + 1'b1 == CW'(ifas_pkg::MaxNodes))
          state_d = ifas_pkg::StCnt;
        else state_d = ifas_pkg::StRead;
      end
      ifas_pkg::StLeaf: state_d = ifas_pkg::StCnt;
      ifas_pkg::StSum: state_d = (bit_q == 6'd1) ? ifas_pkg::StMulC : ifas_pkg::StSum;
      ifas_pkg::StMulC: state_d = ifas_pkg::StDiv;
      ifas_pkg::StDiv: state_d = (bit_q == 6'd1) ? ifas_pkg::StExp : ifas_pkg::StDiv;
      ifas_pkg::StExp: begin
        if (k_q == 5'd17) state_d = ifas_pkg::StOut;
        else if (k_q == 5'd0) state_d = ifas_pkg::StExp;
        else state_d = ifas_pkg::StExpMul;
      end
      ifas_pkg::StExpMul: state_d = ifas_pkg::StExp;
      ifas_pkg::StOut: state_d = ifas_pkg::StIdle;
      default: state_d = ifas_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifas_pkg::StIdle;
      tree_count_q <= 8'd0;
      sample_size_q <= 9'd256;
      feature_count_q <= 3'd3;
      done_q <= 1'b0;
      cnt_vld_rd_q <= 1'b0;
      for (int i = 0; i < ifas_pkg::MaxTrees; i++) cnt_vld_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == ifas_pkg::StOut);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ifas_pkg::CfgTreeCount: tree_count_q <= cfg_data_i[7:0];
          ifas_pkg::CfgSampleSize: sample_size_q <= cfg_data_i;
          ifas_pkg::CfgFeatureCount: feature_count_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cnt_we) cnt_vld_q[ld_tree_q] <= 1'b1;
      cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
    end
  end

  logic [40:0] trial;
  logic [40:0] sh_rem;
  logic [23:0] mean_sat;
  always_comb begin
    sh_rem = {rem_q[39:0], quo_q[40]};
    trial = sh_rem - ((state_q == ifas_pkg::StSum) ? 41'(trees_q) : 41'(cn_q));
    mean_sat = (quo_q[40:24] != '0) ? 24'hFFFFFF : quo_q[23:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ifas_pkg::StIdle: begin
        feat_q[0] <= feature_zero_i;
        feat_q[1] <= feature_one_i;
        feat_q[2] <= feature_two_i;
        feat_q[3] <= feature_three_i;
        nfeat_q <= (feature_count_q > 3'd4) ? 3'd4 : feature_count_q;
        trees_q <= (tree_count_q > 8'd128) ? (TW+1)'(128) : tree_count_q[TW:0];
        ld_tree_q <= tree_index_i;
        ld_node_q <= node_index_i;
        tree_q <= '0;
        idx_q <= '0;
        steps_q <= '0;
        depth_q <= '0;
        sum_q <= '0;
        score_q <= 17'd32768;
        mean_q <= 24'd0;
      end
      ifas_pkg::StTree: begin
        idx_q <= '0;
        steps_q <= '0;
        depth_q <= '0;
        if (tree_q == trees_q) begin
          quo_q <= sum_q;
          rem_q <= '0;
          bit_q <= 6'd41;
        end else if (cur_cnt == '0) tree_q <= tree_q + 1'b1;
      end
      ifas_pkg::StNode: begin
        steps_q <= steps_q + 1'b1;
        if (is_leaf) begin
          // c(leaf_size) is added once the lookup returns
        end else if (child[9]) begin
          sum_q <= sum_q + {depth_q + 1'b1, 16'd0};
          tree_q <= tree_q + 1'b1;
        end else if ({1'b0, child[8:0]} >= cur_cnt ||
                     steps_q + 1'b1 == CW'(ifas_pkg::MaxNodes)) begin
          sum_q <= sum_q + {depth_q + 1'b1, 16'd0};
          tree_q <= tree_q + 1'b1;
        end else begin
          depth_q <= depth_q + 1'b1;
          idx_q <= child[8:0];
        end
      end
      ifas_pkg::StLeaf: begin
        sum_q <= sum_q + {depth_q, 16'd0} + 41'(c_rd_q);
        tree_q <= tree_q + 1'b1;
      end
      ifas_pkg::StSum, ifas_pkg::StDiv: begin
        bit_q <= bit_q - 1'b1;
        if (!trial[40]) begin
          rem_q <= trial;
          quo_q <= {quo_q[39:0], 1'b1};
        end else begin
          rem_q <= sh_rem;
          quo_q <= {quo_q[39:0], 1'b0};
        end
      end
      ifas_pkg::StMulC: begin
        mean_q <= mean_sat;
        quo_q <= {1'b0, mean_sat, 16'd0};
        rem_q <= '0;
        bit_q <= 6'd41;
        cn_q <= (c_rd_q == 32'd0) ? 32'd65536 : c_rd_q;
      end
      ifas_pkg::StExp: begin
        if (k_q == 5'd0) begin
          x_q <= quo_q[31:0];
          s_q <= 33'h1_0000_0000;
          k_q <= 5'd1;
        end else if (k_q != 5'd17) begin
          prod_q <= s_q * r_tab[k_q];
        end
      end
      ifas_pkg::StExpMul: begin
        if (x_q[16 - k_q]) s_q <= 33'((prod_q + 66'h8000_0000) >> 32);
        k_q <= k_q + 1'b1;
      end
      ifas_pkg::StOut: begin
        if (tree_count_q != 8'd0) begin
          if (x_q[31:16] >= 16'd48 || quo_q[40:32] != '0) score_q <= 17'd0;
          else begin
            score_q <= 17'(((82'(s_q) + (82'd1 << (15 + x_q[21:16]))) >>
                            (16 + x_q[21:16])) > 82'd65536 ? 82'd65536 :
                           ((82'(s_q) + (82'd1 << (15 + x_q[21:16]))) >>
                            (16 + x_q[21:16])));
          end
        end
      end
      default: ;
    endcase
    if (state_q == ifas_pkg::StDiv && bit_q == 6'd1) k_q <= 5'd0;
  end
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for isolation_forest_anomaly_score: loads tree nodes,
// scores feature vectors and checks each scored word against a local predictor.
// Depends on ifas_pkg and the RTL of the scorer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 40000000;

  typedef struct {
    logic               action;
    logic [6:0]         tree;
    logic [8:0]         node;
    logic signed [2:0]  sf;
    logic signed [31:0] sv;
    logic signed [9:0]  lc;
    logic signed [9:0]  rc;
    logic [8:0]         size;
    logic [3:0][31:0]   feat;
  } word_t;

  typedef struct {
    logic signed [2:0]  sf;
    logic signed [31:0] sv;
    logic signed [9:0]  lc;
    logic signed [9:0]  rc;
    logic [8:0]         size;
  } forest_node_t;

  typedef struct {
    logic [16:0] score;
    logic [23:0] mean;
  } score_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start, busy, cfg_valid, cfg_ready, done;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  word_t drv;
  logic [16:0] score_out;
  logic [23:0] mean_out;

  forest_node_t forest[ifas_pkg::MaxTrees][ifas_pkg::MaxNodes];
  int unsigned  loaded[ifas_pkg::MaxTrees];
  int unsigned  m_trees, m_samples, m_features;
  logic [31:0]  c_tab[512];
  logic [63:0]  roots[17];
  score_t       pending_scores[$];
  int unsigned  cycles, errors, n_loads, n_scores, n_checked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  isolation_forest_anomaly_score dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .action_i(drv.action), .tree_index_i(drv.tree),
    .node_index_i(drv.node), .split_feature_i(drv.sf), .split_value_i(drv.sv),
    .left_child_i(drv.lc), .right_child_i(drv.rc), .leaf_size_i(drv.size),
    .feature_zero_i(drv.feat[0]), .feature_one_i(drv.feat[1]),
    .feature_two_i(drv.feat[2]), .feature_three_i(drv.feat[3]),
    .done_o(done), .anomaly_score_o(score_out), .mean_path_length_o(mean_out)
  );

  function automatic logic [31:0] expected_path_c(int unsigned n);
    logic [63:0] v, m, frac, ln, c;
    int unsigned e;
    if (n <= 1) return 32'd0;
    if (n == 2) return 32'd65536;
    v = 64'(n - 1);
    e = 0;
    frac = 0;
    while ((v >> (e + 1)) != 0) e++;
    m = v << (30 - e);
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[b] = 1'b1;
      end
    end
    ln = 64'(e) * 64'd2977044472 + ((frac * 64'd2977044472) >> 32);
    c = 64'd2 * (ln + 64'd2479122404) - ((64'(n - 1) << 33) / 64'(n));
    return 32'((c + 64'd32768) >> 16);
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] tree_depth_q16(int unsigned t, logic [3:0][31:0] f,
                                                 int unsigned nf);
    int unsigned idx, steps;
    logic [63:0] depth;
    forest_node_t nd;
    logic signed [9:0] child;
    idx = 0;
    steps = 0;
    depth = 0;
    while (idx < loaded[t] && steps < ifas_pkg::MaxNodes) begin
      nd = forest[t][idx];
      steps++;
      if (nd.sf < 0 || (nd.lc < 0 && nd.rc < 0)) return (depth << 16) + c_tab[nd.size];
      if (int'(nd.sf) < int'(nf) && $signed(f[nd.sf]) < nd.sv) child = nd.lc;
      else child = nd.rc;
      if (child < 0) return (depth + 1) << 16;
      idx = int'(child);
      depth++;
    end
    return depth << 16;
  endfunction

  function automatic score_t predict_score(logic [3:0][31:0] f);
    score_t r;
    int unsigned trees, nf, ip;
    logic [63:0] sum, mean, cn, x, s, sc;
    logic [15:0] fp;
    if (m_trees == 0) begin
      r.score = 17'd32768;
      r.mean = 0;
      return r;
    end
    trees = (m_trees > ifas_pkg::MaxTrees) ? ifas_pkg::MaxTrees : m_trees;
    nf = (m_features > ifas_pkg::MaxFeatures) ? ifas_pkg::MaxFeatures : m_features;
    sum = 0;
    for (int t = 0; t < trees; t++) sum += tree_depth_q16(t, f, nf);
    mean = sum / trees;
    if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
    cn = c_tab[m_samples];
    if (cn == 0) cn = 65536;
    x = (mean << 16) / cn;
    ip = int'(x >> 16);
    fp = x[15:0];
    s = 64'd1 << 32;
    for (int k = 1; k <= 16; k++)
      if (fp[16 - k]) s = (s * roots[k] + (64'd1 << 31)) >> 32;
    if (ip >= 48) sc = 0;
    else sc = (s + (64'd1 << (15 + ip))) >> (16 + ip);
    if (sc > 65536) sc = 65536;
    r.score = sc[16:0];
    r.mean = mean[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    score_t e;
    if (rst_n && done) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: score %0d mean %0d",
                 $time, score_out, mean_out);
      end else begin
        e = pending_scores.pop_front();
        n_checked++;
        if (score_out !== e.score) begin
          errors++;
          $display("%0t: anomaly_score expected %0d actual %0d", $time, e.score, score_out);
        end
        if (mean_out !== e.mean) begin
          errors++;
          $display("%0t: mean_path_length expected %0d actual %0d", $time, e.mean, mean_out);
        end
      end
    end
  end

  task automatic send_word(word_t w);
    start <= 1'b1;
    drv <= w;
    do @(posedge clk); while (busy);
    if (!w.action) begin
      forest[w.tree][w.node] = '{w.sf, w.sv, w.lc, w.rc, w.size};
      if (w.node + 1 > loaded[w.tree]) loaded[w.tree] = w.node + 1;
      n_loads++;
    end else begin
      pending_scores = {pending_scores, predict_score(w.feat)};
      n_scores++;
    end
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ifas_pkg::CfgTreeCount:    m_trees = val & 8'hFF;
      ifas_pkg::CfgSampleSize:   m_samples = val & 9'h1FF;
      ifas_pkg::CfgFeatureCount: m_features = val & 3'h7;
      default: ;
    endcase
  endtask

  function automatic word_t load_word(int t, int n, int sf, logic [31:0] sv, int lc, int rc,
                                      int size);
    word_t w;
    w.action = 1'b0;
    w.tree = t[6:0];
    w.node = n[8:0];
    w.sf = sf[2:0];
    w.sv = sv;
    w.lc = lc[9:0];
    w.rc = rc[9:0];
    w.size = size[8:0];
    for (int k = 0; k < 4; k++) w.feat[k] = $urandom;
    return w;
  endfunction

  function automatic word_t score_word(logic [31:0] f0, logic [31:0] f1, logic [31:0] f2,
                                       logic [31:0] f3);
    word_t w;
    w = load_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    w.action = 1'b1;
    w.feat = {f3, f2, f1, f0};
    return w;
  endfunction

  function automatic logic [31:0] near_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  task automatic test_not_ready();
    send_word(score_word(32'h80000000, 32'h7FFFFFFF, 0, 32'hFFFFFFFF));
    send_word(score_word(0, 0, 0, 0));
  endtask

  task automatic test_directed_trees();
    // tree 0: split, leaf, absent feature, missing right child, big leaf
    send_word(load_word(0, 0, 0, 0, 1, 2, 7));
    send_word(load_word(0, 1, -1, 0, -1, -1, 2));
    send_word(load_word(0, 2, 3, 0, 3, -1, 5));
    send_word(load_word(0, 3, -1, 0, -1, -1, 511));
    // tree 1: leaf marked by most negative feature index
    send_word(load_word(1, 0, -4, 32'h7FFFFFFF, 5, 6, 256));
    // tree 2: self loop, always right
    send_word(load_word(2, 0, 1, 32'h80000000, 0, 0, 9));
    // tree 3 empty; tree 4: child past loaded nodes, leaf by no children
    send_word(load_word(4, 0, 2, 32'h7FFFFFFF, 400, 1, 3));
    send_word(load_word(4, 1, 2, 0, -1, -1, 0));
    send_word(load_word(5, 0, -1, 0, -512, 511, 1));
    write_reg(ifas_pkg::CfgTreeCount, 6);
    send_word(score_word(32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000));
    send_word(score_word(0, 32'h80000000, 32'h80000000, 0));
    write_reg(ifas_pkg::CfgFeatureCount, 0);
    write_reg(ifas_pkg::CfgSampleSize, 0);
    send_word(score_word(32'h80000000, 0, 0, 0));
    write_reg(ifas_pkg::CfgFeatureCount, 7);
    write_reg(ifas_pkg::CfgSampleSize, 1);
    send_word(score_word(32'h80000000, 1, 32'h7FFFFFFE, 32'h80000000));
    write_reg(ifas_pkg::CfgSampleSize, 2);
    send_word(score_word(5, 5, 5, 5));
    write_reg(ifas_pkg::CfgSampleSize, 511);
    write_reg(ifas_pkg::CfgTreeCount, 255);
    send_word(score_word(32'hFFFF0000, 0, 0, 0));
    write_reg(ifas_pkg::CfgTreeCount, 1);
    send_word(score_word(32'h80000000, 0, 0, 0));
  endtask

  task automatic build_tree(int t, output int k);
    k = $urandom_range(1, 15);
    for (int i = 0; i < k; i++) begin
      if (2 * i + 2 < k)
        send_word(load_word(t, i, $urandom_range(0, 3), near_value(), 2 * i + 1, 2 * i + 2,
                            $urandom));
      else
        send_word(load_word(t, i, -1, $urandom, $urandom, $urandom,
                            $urandom_range(0, 300)));
      maybe_gap();
    end
  endtask

  task automatic test_random_phase(int trees, int samples, int feats, int n_items);
    int t, n, sent;
    write_reg(ifas_pkg::CfgTreeCount, trees);
    write_reg(ifas_pkg::CfgSampleSize, samples);
    write_reg(ifas_pkg::CfgFeatureCount, feats);
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          t = $urandom_range(0, 15);
          build_tree(t, n);
          sent += n;
        end
        2: begin
          t = $urandom_range(0, 15);
          n = $urandom_range(0, (loaded[t] > 511) ? 511 : loaded[t]);
          send_word(load_word(t, n, $urandom, $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        default: begin
          send_word(score_word(near_value(), near_value(), near_value(), near_value()));
          sent++;
        end
      endcase
      if ($urandom_range(0, 2) != 0) maybe_gap();
    end
  endtask

  initial begin
    for (int n = 0; n < 512; n++) c_tab[n] = expected_path_c(n);
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) roots[k] = sqrt_floor(roots[k - 1] << 32);
    for (int t = 0; t < ifas_pkg::MaxTrees; t++) loaded[t] = 0;
    m_trees = 0;
    m_samples = 256;
    m_features = 3;
    cycles = 0;
    errors = 0;
    n_loads = 0;
    n_scores = 0;
    n_checked = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= ifas_pkg::CfgTreeCount;
    cfg_data <= 0;
    drv <= load_word(0, 0, 0, 0, 0, 0, 0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_directed_trees();
    test_random_phase(1, 256, 4, 100);
    test_random_phase(8, $urandom_range(3, 255), 1, 100);
    test_random_phase(16, 1, 3, 100);
    test_random_phase(128, $urandom_range(0, 511), $urandom_range(0, 7), 80);
    test_random_phase($urandom_range(2, 12), 511, 2, 100);
    test_random_phase(0, 256, 3, 30);
    test_random_phase($urandom_range(1, 16), $urandom_range(0, 511), $urandom_range(0, 7),
                      50);
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d node loads and %0d scores, %0d results checked.",
             n_loads, n_scores, n_checked);
    $display("Forest sizes from empty to 255 trees, all register extremes exercised.");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
